@@ rtl/core/llca_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// llca_pkg: shared types and codes of the life-like automaton
// Item mode codes, configuration register indexes and the edit command
// broadcast from the top level to every row cell.
// ----------------------------------------------------------------------------
package llca_pkg;

    // coordinate and mask widths fixed by the item fields
    localparam int COORD_W = 6;
    localparam int MASK_W  = 9;
    localparam int COUNT_W = 4;
    localparam int GENS_W  = 8;
    localparam int LEFT_W  = 9;
    localparam int OUT_W   = 64;

    // item modes
    localparam logic [1:0] MODE_EDIT    = 2'd0;
    localparam logic [1:0] MODE_ADVANCE = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;

    // configuration register indexes
    localparam logic CFG_SURVIVE = 1'b0;
    localparam logic CFG_BORN    = 1'b1;

    // edit command seen by all row cells
    typedef struct packed {
        logic               set_en;
        logic [COORD_W-1:0] set_x;
        logic [COORD_W-1:0] set_y;
        logic               clr_en;
        logic [COORD_W-1:0] clr_x;
        logic [COORD_W-1:0] clr_y;
    } edit_cmd_t;

endpackage
`default_nettype wire

@@ rtl/core/life_like_cellular_automaton_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// life_like_cellular_automaton_top: life-like automaton on a row chain
// Grid rows sit in a chain of row cells that rotates through one rule unit.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy low; its single result appears
// on row_cells/row_index for exactly one cycle with done high, and the receiver
// cannot stall it. Edit items (and unused mode codes) finish at once: done
// comes the cycle after acceptance and busy never rises. A read item makes one
// full sweep of the row chain and an advance item gens_minus_one+1 sweeps, as
// the row chain rotates one row per cycle past the rule unit and a read waits
// for its row to reach the head of the chain. Configuration writes are always
// accepted (cfg_ready is tied high) and must only be issued while idle.
// ----------------------------------------------------------------------------
module life_like_cellular_automaton_top #(
    parameter int GRID_COLS = 64,
    parameter int GRID_ROWS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item command
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  mode,
    input  wire logic [5:0]  set_x,
    input  wire logic [5:0]  set_y,
    input  wire logic        set_enable,
    input  wire logic [5:0]  clear_x,
    input  wire logic [5:0]  clear_y,
    input  wire logic        clear_enable,
    input  wire logic [7:0]  gens_minus_one,
    input  wire logic [5:0]  read_row,
    // result
    output logic             done,
    output logic [63:0]      row_cells,
    output logic [5:0]       row_index,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [8:0]  cfg_data
);

    localparam int RW = $clog2(GRID_ROWS);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_SWEEP = 2'b10
    } state_t;

    state_t                        state_reg, state_next;
    logic [RW-1:0]                 row_cnt_reg, row_cnt_next;
    logic [llca_pkg::LEFT_W-1:0]   gens_left_reg, gens_left_next;
    logic                          is_gen_reg, is_gen_next;
    logic [llca_pkg::COORD_W-1:0]  read_row_reg, read_row_next;
    logic [llca_pkg::OUT_W-1:0]    row_cells_reg, row_cells_next;
    logic [llca_pkg::COORD_W-1:0]  row_index_reg, row_index_next;
    logic                          done_reg, done_next;
    logic [llca_pkg::MASK_W-1:0]   survive_reg, born_reg;
    logic [GRID_COLS-1:0]          prior_reg;

    logic                          accept;
    logic                          sweeping;
    logic                          last_row;
    logic                          border;
    logic                          edit_en;
    llca_pkg::edit_cmd_t           edit_cmd;
    logic [GRID_COLS-1:0]          rows [GRID_ROWS];
    logic [GRID_COLS-1:0]          tail_row;
    logic [GRID_COLS-1:0]          rule_row;
    logic [GRID_COLS-1:0]          below_row;

    assign sweeping = (state_reg == ST_SWEEP);
    assign busy     = sweeping;
    assign accept   = start && !busy;
    assign last_row = (row_cnt_reg == RW'(GRID_ROWS - 1));
    assign border   = (row_cnt_reg == '0) || last_row;
    assign edit_en  = accept && (mode == llca_pkg::MODE_EDIT);

    // edit command broadcast
    always_comb
    begin
        edit_cmd.set_en = set_enable;
        edit_cmd.set_x  = set_x;
        edit_cmd.set_y  = set_y;
        edit_cmd.clr_en = clear_enable;
        edit_cmd.clr_x  = clear_x;
        edit_cmd.clr_y  = clear_y;
    end

    // row chain: cell i takes the row of cell i+1, the last takes the tail row
    for (genvar i = 0; i < GRID_ROWS; i++)
    begin : g_row
        logic [GRID_COLS-1:0] shift_in;
        if (i == GRID_ROWS - 1)
        begin : g_tail
            assign shift_in = tail_row;
        end
        else
        begin : g_link
            assign shift_in = rows[i+1];
        end
        llca_row_cell #(
            .GRID_COLS (GRID_COLS),
            .ROW_IDX   (i)
        ) u_row (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (sweeping),
            .shift_in (shift_in),
            .edit_en  (edit_en),
            .edit_cmd (edit_cmd),
            .row      (rows[i])
        );
    end

    assign below_row = rows[1];

    // rule unit on the head of the chain
    llca_rule #(
        .GRID_COLS (GRID_COLS)
    ) u_rule (
        .above        (prior_reg),
        .cur          (rows[0]),
        .below        (below_row),
        .border       (border),
        .survive_mask (survive_reg),
        .born_mask    (born_reg),
        .next_row     (rule_row)
    );

    // an advance writes back the new row, a read puts the old one back
    assign tail_row = is_gen_reg ? rule_row : rows[0];

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        row_cnt_next   = row_cnt_reg;
        gens_left_next = gens_left_reg;
        is_gen_next    = is_gen_reg;
        read_row_next  = read_row_reg;
        row_cells_next = row_cells_reg;
        row_index_next = row_index_reg;
        done_next      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    row_cnt_next   = '0;
                    row_cells_next = '0;
                    row_index_next = '0;
                    read_row_next  = read_row;
                    gens_left_next = llca_pkg::LEFT_W'(gens_minus_one) + 9'd1;
                    priority if (mode == llca_pkg::MODE_ADVANCE)
                    begin
                        is_gen_next = 1'b1;
                        state_next  = ST_SWEEP;
                    end
                    else if (mode == llca_pkg::MODE_READ)
                    begin
                        is_gen_next    = 1'b0;
                        row_index_next = read_row;
                        state_next     = ST_SWEEP;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            ST_SWEEP:
            begin
                // capture the requested row as it passes the head
                if (!is_gen_reg && (llca_pkg::COORD_W'(row_cnt_reg) == read_row_reg))
                begin
                    row_cells_next = llca_pkg::OUT_W'(rows[0]);
                end
                if (last_row)
                begin
                    row_cnt_next = '0;
                    if (is_gen_reg && (gens_left_reg > 9'd1))
                    begin
                        gens_left_next = gens_left_reg - 9'd1;
                    end
                    else
                    begin
                        gens_left_next = '0;
                        state_next     = ST_IDLE;
                        done_next      = 1'b1;
                    end
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + RW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_cnt_reg   <= '0;
            gens_left_reg <= '0;
            is_gen_reg    <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_cnt_reg   <= row_cnt_next;
            gens_left_reg <= gens_left_next;
            is_gen_reg    <= is_gen_next;
            done_reg      <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        read_row_reg  <= read_row_next;
        row_cells_reg <= row_cells_next;
        row_index_reg <= row_index_next;
    end

    // old row above the head, kept while sweeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_reg <= '0;
        end
        else if (sweeping)
        begin
            prior_reg <= rows[0];
        end
    end

    // rule masks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            survive_reg <= 9'd12;
            born_reg    <= 9'd8;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                llca_pkg::CFG_SURVIVE: survive_reg <= cfg_data;
                llca_pkg::CFG_BORN:    born_reg    <= cfg_data;
                default:               survive_reg <= survive_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign row_cells = row_cells_reg;
    assign row_index = row_index_reg;

endmodule
`default_nettype wire

@@ rtl/core/llca_row_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// llca_row_cell: one grid row of the rotating row chain
// Holds one row of cells. While the chain rotates it takes the row of its
// neighbour; while idle it applies edit commands aimed at its own row.
// ----------------------------------------------------------------------------
module llca_row_cell #(
    parameter int GRID_COLS = 64,
    parameter int ROW_IDX   = 0
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   shift_en,
    input  wire logic [GRID_COLS-1:0]   shift_in,
    input  wire logic                   edit_en,
    input  wire llca_pkg::edit_cmd_t    edit_cmd,
    output logic      [GRID_COLS-1:0]   row
);

    logic [GRID_COLS-1:0] row_reg;
    logic [GRID_COLS-1:0] set_mask;
    logic [GRID_COLS-1:0] clr_mask;
    logic                 row_ok;

    // top border row (row 0) never takes edits
    assign row_ok = (ROW_IDX != 0);

    // decode one-hot set and clear masks for this row, column 0 excluded
    always_comb
    begin
        set_mask = '0;
        clr_mask = '0;
        for (int c = 1; c < GRID_COLS; c++)
        begin
            set_mask[c] = row_ok && edit_cmd.set_en
                          && (edit_cmd.set_x == llca_pkg::COORD_W'(c))
                          && (edit_cmd.set_y == llca_pkg::COORD_W'(ROW_IDX));
            clr_mask[c] = row_ok && edit_cmd.clr_en
                          && (edit_cmd.clr_x == llca_pkg::COORD_W'(c))
                          && (edit_cmd.clr_y == llca_pkg::COORD_W'(ROW_IDX));
        end
    end

    // row storage: rotate or edit (set first, then clear)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else if (shift_en)
        begin
            row_reg <= shift_in;
        end
        else if (edit_en)
        begin
            row_reg <= (row_reg | set_mask) & ~clr_mask;
        end
    end

    assign row = row_reg;

endmodule
`default_nettype wire

@@ rtl/core/llca_rule.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// llca_rule: next-generation row unit
// Counts the live neighbours of every interior cell of the current row from
// the rows above and below and applies the birth or survival mask.
// ----------------------------------------------------------------------------
module llca_rule #(
    parameter int GRID_COLS = 64
) (
    input  wire logic [GRID_COLS-1:0]        above,
    input  wire logic [GRID_COLS-1:0]        cur,
    input  wire logic [GRID_COLS-1:0]        below,
    input  wire logic                        border,
    input  wire logic [llca_pkg::MASK_W-1:0] survive_mask,
    input  wire logic [llca_pkg::MASK_W-1:0] born_mask,
    output logic      [GRID_COLS-1:0]        next_row
);

    logic [llca_pkg::COUNT_W-1:0] count [GRID_COLS];

    // per-column neighbour count, edge columns stay dead
    always_comb
    begin
        next_row = '0;
        for (int x = 0; x < GRID_COLS; x++)
        begin
            count[x] = '0;
        end
        for (int x = 1; x < GRID_COLS - 1; x++)
        begin
            count[x] = llca_pkg::COUNT_W'(above[x-1]) + llca_pkg::COUNT_W'(above[x])
                     + llca_pkg::COUNT_W'(above[x+1]) + llca_pkg::COUNT_W'(cur[x-1])
                     + llca_pkg::COUNT_W'(cur[x+1])   + llca_pkg::COUNT_W'(below[x-1])
                     + llca_pkg::COUNT_W'(below[x])   + llca_pkg::COUNT_W'(below[x+1]);
            if (!border)
            begin
                next_row[x] = cur[x] ? survive_mask[count[x]] : born_mask[count[x]];
            end
        end
    end

endmodule
`default_nettype wire
